@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/fifcm_pkg.sv @@
// ----------------------------------------------------------------------------
// fifcm_pkg
// Shared constants, types and arithmetic for the fern chaos-game claim map.
// ----------------------------------------------------------------------------
package fifcm_pkg;

    // Grid geometry
    localparam int GRID_W = 96;
    localparam int GRID_H = 160;
    localparam int GX_W   = $clog2(GRID_W);
    localparam int GY_W   = $clog2(GRID_H);
    localparam int IDX_W  = 14;

    // Number formats
    localparam int COORD_W = 22;
    localparam int FRAC_W  = 16;
    localparam int COEF_W  = 18;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SUM_W   = ACC_W - FRAC_W + 1;
    localparam int STEP_W  = 32;
    localparam int BURN_W  = 16;
    localparam int RAND_W  = 16;

    // Window: x in [-3,3], y in [0,10]; both spans divide into power-of-two cells
    localparam int FX_ONE       = 1 << FRAC_W;
    localparam int X_SPAN       = 6 * FX_ONE;
    localparam int Y_SPAN       = 10 * FX_ONE;
    localparam int CELL_X_SHIFT = $clog2(X_SPAN / GRID_W);
    localparam int CELL_Y_SHIFT = $clog2(Y_SPAN / GRID_H);

    localparam logic signed [COORD_W-1:0] X_LO   = -COORD_W'(3 * FX_ONE);
    localparam logic signed [COORD_W-1:0] X_HI   = COORD_W'(3 * FX_ONE);
    localparam logic signed [COORD_W-1:0] Y_HI   = COORD_W'(Y_SPAN);
    localparam logic signed [COORD_W:0]   X_BIAS = (COORD_W+1)'(3 * FX_ONE);

    localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(2097151);
    localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(2097152);
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(32768);

    // Map thresholds on the raw fraction
    localparam logic [RAND_W-1:0] TH_STEM = RAND_W'(656);
    localparam logic [RAND_W-1:0] TH_MAIN = RAND_W'(56361);
    localparam logic [RAND_W-1:0] TH_LEFT = RAND_W'(60949);

    typedef logic [GRID_W-1:0] row_t;

    typedef enum logic [1:0] {
        MAP_STEM,
        MAP_MAIN,
        MAP_LEFT,
        MAP_RIGHT
    } map_sel_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] ax;
        logic signed [COEF_W-1:0] bx;
        logic signed [COEF_W-1:0] ox;
        logic signed [COEF_W-1:0] ay;
        logic signed [COEF_W-1:0] by;
        logic signed [COEF_W-1:0] oy;
    } coef_t;

    // Claim memory access requests from the pipeline
    typedef struct packed {
        logic            rd_en;
        logic [GY_W-1:0] rd_row;
        logic            wr_en;
        logic [GY_W-1:0] wr_row;
    } claim_req_t;

    // Pick the map from the random fraction
    function automatic map_sel_t map_select(input logic [RAND_W-1:0] r);
        map_sel_t m;
        if (r < TH_STEM)      m = MAP_STEM;
        else if (r < TH_MAIN) m = MAP_MAIN;
        else if (r < TH_LEFT) m = MAP_LEFT;
        else                  m = MAP_RIGHT;
        return m;
    endfunction

    // Q16 coefficients of the four maps
    function automatic coef_t map_coefs(input map_sel_t m);
        coef_t c;
        case (m)
            MAP_STEM: begin
                c = '{ax: 18'sd0, bx: 18'sd0, ox: 18'sd0,
                      ay: 18'sd0, by: 18'sd10486, oy: 18'sd0};
            end
            MAP_MAIN: begin
                c = '{ax: 18'sd55706, bx: 18'sd2621, ox: 18'sd0,
                      ay: -18'sd2621, by: 18'sd55706, oy: 18'sd104858};
            end
            MAP_LEFT: begin
                c = '{ax: 18'sd13107, bx: -18'sd17039, ox: 18'sd0,
                      ay: 18'sd15073, by: 18'sd14418, oy: 18'sd104858};
            end
            MAP_RIGHT: begin
                c = '{ax: -18'sd9830, bx: 18'sd18350, ox: 18'sd0,
                      ay: 18'sd17039, by: 18'sd15729, oy: 18'sd28836};
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    // a*x + b*y, rounded half up to Q16, plus offset, saturated
    function automatic logic signed [COORD_W-1:0] affine(
        input logic signed [COEF_W-1:0]  a,
        input logic signed [COEF_W-1:0]  b,
        input logic signed [COEF_W-1:0]  off,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        logic signed [PROD_W-1:0]       px;
        logic signed [PROD_W-1:0]       py;
        logic signed [ACC_W-1:0]        acc;
        logic signed [ACC_W-FRAC_W-1:0] sh;
        logic signed [SUM_W-1:0]        v;
        logic signed [COORD_W-1:0]      res;
        px  = a * x;
        py  = b * y;
        acc = ACC_W'(px) + ACC_W'(py) + HALF;
        sh  = acc[ACC_W-1:FRAC_W];
        v   = SUM_W'(sh) + SUM_W'(off);
        if (v > Q_MAX)      res = Q_MAX[COORD_W-1:0];
        else if (v < Q_MIN) res = Q_MIN[COORD_W-1:0];
        else                res = v[COORD_W-1:0];
        return res;
    endfunction

endpackage

@@ hdl/fifcm_claim_mem.sv @@
// ----------------------------------------------------------------------------
// fifcm_claim_mem
// Row-wide claim bitmap with registered read and a clearing
// sweep of one row per cycle after reset.
// ----------------------------------------------------------------------------
module fifcm_claim_mem
    import fifcm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  claim_req_t req,
    input  row_t       wr_data,
    output row_t       rd_data,
    output logic       busy
);

    row_t            claim_mem [GRID_H];
    row_t            rd_data_reg;
    logic            clearing_reg;
    logic [GY_W-1:0] clr_row_reg;

    // Sweep the rows after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_row_reg == GY_W'(GRID_H - 1)) begin
                clearing_reg <= 1'b0;
            end
            clr_row_reg <= clr_row_reg + 1'b1;
        end
    end

    // Write one row, read one row
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            claim_mem[clr_row_reg] <= '0;
        end else if (req.wr_en) begin
            claim_mem[req.wr_row] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= claim_mem[req.rd_row];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

@@ hdl/fern_ifs_first_claim_map_top.sv @@
// A word passes stage 1, stage 2 and the result register, in that order.
// Throughput: one word per cycle unless m_ready is low or the sweep runs; the
// point update is combinational on the kept coordinates and the claim row
// read-modify-write is forwarded. Reset reloads coordinates, step count and
// burn-in (120) at once; the claim map is swept one row per cycle, s_ready low.
// Configuration writes are taken on any cycle, the sweep included.
// ----------------------------------------------------------------------------
// fern_ifs_first_claim_map_top
// Barnsley fern chaos game with a first-hit claim map over a window grid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fern_ifs_first_claim_map_top
    import fifcm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [BURN_W-1:0]         cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RAND_W-1:0]         s_rand_fraction,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_point_x,
    output logic signed [COORD_W-1:0] m_point_y,
    output logic                      m_in_window,
    output logic [IDX_W-1:0]          m_cell_index,
    output logic                      m_new_claim,
    output logic [STEP_W-1:0]         m_claim_step
);

    // Kept state
    logic [BURN_W-1:0]         burn_reg;
    logic signed [COORD_W-1:0] cur_x_reg;
    logic signed [COORD_W-1:0] cur_y_reg;
    logic [STEP_W-1:0]         iter_reg;

    // Stage 1: new point
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic                      s1_past_reg;
    logic [STEP_W-1:0]         s1_cstep_reg;

    // Stage 2: cell and row read
    logic                      s2_valid_reg;
    logic signed [COORD_W-1:0] s2_x_reg;
    logic signed [COORD_W-1:0] s2_y_reg;
    logic                      s2_win_reg;
    logic [GX_W-1:0]           s2_gx_reg;
    logic [GY_W-1:0]           s2_gy_reg;
    logic [STEP_W-1:0]         s2_cstep_reg;

    // Last row written, for forwarding
    logic                      wb_valid_reg;
    logic [GY_W-1:0]           wb_row_reg;
    row_t                      wb_data_reg;

    // Result register
    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] m_x_reg;
    logic signed [COORD_W-1:0] m_y_reg;
    logic                      m_win_reg;
    logic [IDX_W-1:0]          m_idx_reg;
    logic                      m_claim_reg;
    logic [STEP_W-1:0]         m_cstep_reg;

    logic                      mem_busy;
    row_t                      mem_rd_data;
    claim_req_t                mem_req;

    logic                      in_acc;
    logic                      out_free;
    logic                      s2_adv;
    logic                      s2_load;
    logic                      s1_adv;
    logic                      s1_load;

    map_sel_t                  map_sel;
    coef_t                     coef;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic                      stuck;
    logic                      past;
    logic [STEP_W-1:0]         cstep;

    logic                      win1;
    logic signed [COORD_W:0]   ux;
    logic [GX_W:0]             gx_raw;
    logic [GY_W:0]             gy_raw;
    logic [GX_W-1:0]           gx1;
    logic [GY_W-1:0]           gy1;

    row_t                      row_cur;
    row_t                      row_new;
    logic                      hit;
    logic                      claim2;
    logic [IDX_W-1:0]          idx2;

    // Handshake chain
    assign out_free = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_load  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_load;
    assign s1_load  = !s1_valid_reg || s1_adv;
    assign s_ready  = !mem_busy && s1_load;
    assign in_acc   = s_valid && s_ready;

    // Affine update on the kept point
    always_comb begin
        map_sel = map_select(s_rand_fraction);
        coef    = map_coefs(map_sel);
        nx      = affine(coef.ax, coef.bx, coef.ox, cur_x_reg, cur_y_reg);
        ny      = affine(coef.ay, coef.by, coef.oy, cur_x_reg, cur_y_reg);
        stuck   = (iter_reg == '1);
        past    = (iter_reg >= STEP_W'(burn_reg));
        cstep   = stuck ? '1 : (iter_reg - STEP_W'(burn_reg) + STEP_W'(1));
    end

    // Window test and clamped cell
    always_comb begin
        win1   = s1_past_reg && (s1_x_reg >= X_LO) && (s1_x_reg <= X_HI)
                 && (s1_y_reg >= 0) && (s1_y_reg <= Y_HI);
        ux     = (COORD_W+1)'(s1_x_reg) + X_BIAS;
        gx_raw = ux[CELL_X_SHIFT +: GX_W+1];
        gy_raw = s1_y_reg[CELL_Y_SHIFT +: GY_W+1];
        gx1    = (gx_raw > (GX_W+1)'(GRID_W - 1)) ? GX_W'(GRID_W - 1) : gx_raw[GX_W-1:0];
        gy1    = (gy_raw > (GY_W+1)'(GRID_H - 1)) ? GY_W'(GRID_H - 1) : gy_raw[GY_W-1:0];
    end

    // Claim test on the forwarded row
    always_comb begin
        row_cur = (wb_valid_reg && (wb_row_reg == s2_gy_reg)) ? wb_data_reg : mem_rd_data;
        hit     = row_cur[s2_gx_reg];
        claim2  = s2_win_reg && !hit;
        row_new = row_cur;
        row_new[s2_gx_reg] = 1'b1;
        idx2    = s2_win_reg ? (IDX_W'(s2_gy_reg) * IDX_W'(GRID_W) + IDX_W'(s2_gx_reg)) : '0;
    end

    always_comb begin
        mem_req.rd_en  = s1_adv;
        mem_req.rd_row = gy1;
        mem_req.wr_en  = s2_adv && s2_win_reg;
        mem_req.wr_row = s2_gy_reg;
    end

    fifcm_claim_mem u_claim_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .wr_data (row_new),
        .rd_data (mem_rd_data),
        .busy    (mem_busy)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burn_reg     <= BURN_W'(120);
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            iter_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                burn_reg <= cfg_wr_data;
            end
            if (in_acc) begin
                cur_x_reg <= nx;
                cur_y_reg <= ny;
                if (!stuck) begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
            if (s1_load) begin
                s1_valid_reg <= in_acc;
            end
            if (s2_load) begin
                s2_valid_reg <= s1_adv;
            end
            if (out_free) begin
                m_valid_reg <= s2_adv;
            end
            if (mem_req.wr_en) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_x_reg     <= nx;
            s1_y_reg     <= ny;
            s1_past_reg  <= past;
            s1_cstep_reg <= past ? cstep : '0;
        end
        if (s1_adv) begin
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_win_reg   <= win1;
            s2_gx_reg    <= gx1;
            s2_gy_reg    <= gy1;
            s2_cstep_reg <= s1_cstep_reg;
        end
        if (mem_req.wr_en) begin
            wb_row_reg  <= s2_gy_reg;
            wb_data_reg <= row_new;
        end
        if (s2_adv) begin
            m_x_reg     <= s2_x_reg;
            m_y_reg     <= s2_y_reg;
            m_win_reg   <= s2_win_reg;
            m_idx_reg   <= idx2;
            m_claim_reg <= claim2;
            m_cstep_reg <= s2_cstep_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_point_x    = m_x_reg;
    assign m_point_y    = m_y_reg;
    assign m_in_window  = m_win_reg;
    assign m_cell_index = m_idx_reg;
    assign m_new_claim  = m_claim_reg;
    assign m_claim_step = m_cstep_reg;

    // Checks
    `ASSERT_CLK(a_no_accept_while_clearing, aclk, aresetn, mem_busy |-> !s_ready, "word accepted during claim map sweep")
    `ASSERT_CLK(a_claim_needs_window, aclk, aresetn, m_valid |-> (!m_new_claim || m_in_window), "new claim outside window")
    `ASSERT_CLK(a_no_double_claim, aclk, aresetn, (m_valid && m_ready && m_in_window && $past(m_valid && m_ready && m_in_window) && (m_cell_index == $past(m_cell_index))) |-> !m_new_claim, "cell claimed twice in a row")

endmodule
